// ===== src/hrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hrgb_pkg
// Types, constants and arithmetic helpers for the rainbow HSV to RGB unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hrgb_pkg;

   localparam logic [7:0] LEVEL_FULL  = 8'd255;
   localparam logic [7:0] LEVEL_ZERO  = 8'd0;
   localparam logic [7:0] LEVEL_THIRD = 8'd85;
   localparam logic [7:0] LEVEL_TWO3  = 8'd170;
   localparam logic [7:0] LEVEL_171   = 8'd171;
   localparam logic [4:0] POS_MASK    = 5'h1F;

   typedef enum logic [2:0] {
      SEG_RED    = 3'd0,
      SEG_ORANGE = 3'd1,
      SEG_YELLOW = 3'd2,
      SEG_GREEN  = 3'd3,
      SEG_AQUA   = 3'd4,
      SEG_BLUE   = 3'd5,
      SEG_PURPLE = 3'd6,
      SEG_PINK   = 3'd7
   } hrgb_seg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } hrgb_color_type;

   // after hue mapping
   typedef struct packed {
      hrgb_color_type color;
      logic [7:0]     sat_level;
      logic [7:0]     desat_floor;
      logic           blend_en;
      logic [7:0]     bright_scale;
      logic           bright_en;
   } hrgb_blend_type;

   // after saturation blend
   typedef struct packed {
      hrgb_color_type color;
      logic [7:0]     bright_scale;
      logic           bright_en;
   } hrgb_shade_type;

   // (a * (b + 1)) >> 8
   function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] prod;
      prod = 16'(a) * (16'(b) + 16'd1);
      return prod[15:8];
   endfunction

   function automatic logic [7:0] add_sat8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = 9'(a) + 9'(b);
      return sum[8] ? LEVEL_FULL : sum[7:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/hrgb_if.sv =====
// ----------------------------------------------------------------------------
// hrgb_if
// Valid/ready channels carrying HSV request items and RGB response items.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrgb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] hue_angle;
   logic [7:0] sat_level;
   logic [7:0] bright_level;

   modport source (output valid, hue_angle, sat_level, bright_level, input ready);
   modport sink   (input valid, hue_angle, sat_level, bright_level, output ready);
endinterface

interface hrgb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

// ===== src/hrgb_hue_stage.sv =====
// ----------------------------------------------------------------------------
// hrgb_hue_stage
// Stage 1: rainbow segment lookup, desaturation floor and brightness square.
// ----------------------------------------------------------------------------
`default_nettype none

module hrgb_hue_stage
   import hrgb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output      logic           in_ready,
   input  wire logic [7:0]     hue_angle,
   input  wire logic [7:0]     sat_level,
   input  wire logic [7:0]     bright_level,
   output      logic           out_valid,
   input  wire logic           out_ready,
   output      hrgb_blend_type out_data
);

   logic           valid_ff;
   hrgb_blend_type data_ff;
   hrgb_blend_type data_in;
   hrgb_seg_type   seg;
   logic [7:0]     pos;
   logic [7:0]     third;
   logic [7:0]     two3;
   logic [7:0]     desat;

   assign seg   = hrgb_seg_type'(hue_angle[7:5]);
   assign pos   = {hue_angle[4:0] & POS_MASK, 3'b000};
   assign third = scale8(pos, LEVEL_THIRD);
   assign two3  = scale8(pos, LEVEL_TWO3);
   assign desat = LEVEL_FULL - sat_level;

   always_comb begin
      unique case (seg)
         SEG_RED: begin
            data_in.color = '{LEVEL_FULL - third, third, LEVEL_ZERO};
         end
         SEG_ORANGE: begin
            data_in.color = '{LEVEL_171, LEVEL_THIRD + third, LEVEL_ZERO};
         end
         SEG_YELLOW: begin
            data_in.color = '{LEVEL_171 - two3, LEVEL_TWO3 + third, LEVEL_ZERO};
         end
         SEG_GREEN: begin
            data_in.color = '{LEVEL_ZERO, LEVEL_FULL - third, third};
         end
         SEG_AQUA: begin
            data_in.color = '{LEVEL_ZERO, LEVEL_171 - two3, LEVEL_THIRD + two3};
         end
         SEG_BLUE: begin
            data_in.color = '{third, LEVEL_ZERO, LEVEL_FULL - third};
         end
         SEG_PURPLE: begin
            data_in.color = '{LEVEL_THIRD + third, LEVEL_ZERO, LEVEL_171 - third};
         end
         SEG_PINK: begin
            data_in.color = '{LEVEL_TWO3 + third, LEVEL_ZERO, LEVEL_THIRD - third};
         end
      endcase
      // zero saturation: white
      if (sat_level == LEVEL_ZERO) begin
         data_in.color = '{LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};
      end
      data_in.sat_level    = sat_level;
      data_in.desat_floor  = scale8(desat, desat);
      data_in.blend_en     = (sat_level != LEVEL_ZERO) && (sat_level != LEVEL_FULL);
      data_in.bright_scale = scale8(bright_level, bright_level);
      data_in.bright_en    = (bright_level != LEVEL_FULL);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== src/hrgb_sat_stage.sv =====
// ----------------------------------------------------------------------------
// hrgb_sat_stage
// Stage 2: blends the segment color toward white by saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module hrgb_sat_stage
   import hrgb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output      logic           in_ready,
   input  wire hrgb_blend_type in_data,
   output      logic           out_valid,
   input  wire logic           out_ready,
   output      hrgb_shade_type out_data
);

   logic           valid_ff;
   hrgb_shade_type data_ff;
   hrgb_shade_type data_in;

   function automatic logic [7:0] blend(input logic [7:0] ch, input hrgb_blend_type d);
      return d.blend_en ? add_sat8(scale8(ch, d.sat_level), d.desat_floor) : ch;
   endfunction

   always_comb begin
      data_in.color.red    = blend(in_data.color.red, in_data);
      data_in.color.green  = blend(in_data.color.green, in_data);
      data_in.color.blue   = blend(in_data.color.blue, in_data);
      data_in.bright_scale = in_data.bright_scale;
      data_in.bright_en    = in_data.bright_en;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== src/hrgb_bright_stage.sv =====
// ----------------------------------------------------------------------------
// hrgb_bright_stage
// Stage 3: brightness scaling into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrgb_bright_stage
   import hrgb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output      logic           in_ready,
   input  wire hrgb_shade_type in_data,
   output      logic           out_valid,
   input  wire logic           out_ready,
   output      hrgb_color_type out_data
);

   logic           valid_ff;
   hrgb_color_type data_ff;
   hrgb_color_type data_in;

   function automatic logic [7:0] shade(input logic [7:0] ch, input hrgb_shade_type d);
      return d.bright_en ? scale8(ch, d.bright_scale) : ch;
   endfunction

   always_comb begin
      data_in.red   = shade(in_data.color.red, in_data);
      data_in.green = shade(in_data.color.green, in_data);
      data_in.blue  = shade(in_data.color.blue, in_data);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== src/hsv_rainbow_to_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb_unit
// Rainbow-map HSV to RGB converter, 8 bits per channel.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one HSV item (hue_angle, sat_level, bright_level) per
//   valid/ready handshake; rsp_ch returns one RGB item (red_out, green_out,
//   blue_out) for each, in order.
//   Three register stages: hue map, saturation blend, brightness scale.
//   An accepted item moves through the hue, saturation and brightness
//   registers in order before rsp_ch.valid rises. One item per cycle is
//   sustained while rsp_ch.ready stays high, since each stage reloads
//   whenever its successor moves on. Reset clears only the stage valid bits.
//   When the receiver drops rsp_ch.ready the pipeline fills and holds;
//   req_ch.ready falls only once all three stages are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_rainbow_to_rgb_unit
   import hrgb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   hrgb_req_if.sink    req_ch,
   hrgb_rsp_if.source  rsp_ch
);

   logic           s1_valid;
   logic           s1_ready;
   hrgb_blend_type s1_data;
   logic           s2_valid;
   logic           s2_ready;
   hrgb_shade_type s2_data;
   hrgb_color_type s3_data;

   hrgb_hue_stage u_hue (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_ch.valid),
      .in_ready     (req_ch.ready),
      .hue_angle    (req_ch.hue_angle),
      .sat_level    (req_ch.sat_level),
      .bright_level (req_ch.bright_level),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .out_data     (s1_data)
   );

   hrgb_sat_stage u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   hrgb_bright_stage u_bright (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (s3_data)
   );

   assign rsp_ch.red_out   = s3_data.red;
   assign rsp_ch.green_out = s3_data.green;
   assign rsp_ch.blue_out  = s3_data.blue;

`ifndef SYNTHESIS
   // an open sink lets every stage advance
   a_ready_chain: assert property (@(posedge clock)
      rsp_ch.ready |-> req_ch.ready)
      else $error("input stalled while output is ready");

   a_s1_load: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> s1_valid)
      else $error("accepted item missing from stage 1");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid && !s2_ready |=> s2_valid && $stable(s2_data))
      else $error("stage 2 item lost under stall");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_hsv_rainbow_to_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// tb_hsv_rainbow_to_rgb_unit
// Self-checking bench for the rainbow HSV to RGB unit. A directed table covers
// segment starts, field extremes and the white and black corners. Random HSV
// items follow under three idle profiles on the request and response sides.
// Responses are checked per channel vs typed rows or an in-bench color model.
// ----------------------------------------------------------------------------
module tb_hsv_rainbow_to_rgb_unit;
   import hrgb_pkg::*;

   localparam int N_DIRECTED   = 20;
   localparam int N_RANDOM     = 1500;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [7:0]     hue;
      logic [7:0]     sat;
      logic [7:0]     bri;
      logic           typed;
      hrgb_color_type rgb;
   } hsv_row_type;

   logic clock;
   logic reset;

   hrgb_req_if req_ch ();
   hrgb_rsp_if rsp_ch ();

   hsv_rainbow_to_rgb_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   hrgb_color_type rgb_expect_q [$];
   hrgb_color_type next_rgb;
   int             err_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct;
   int             recv_stall_pct;

   // typed rows: full sat/bright segment starts, white, black
   hsv_row_type hsv_rows [0:N_DIRECTED-1] = '{
      '{8'h00, 8'hFF, 8'hFF, 1'b1, '{8'd255, 8'd0,   8'd0  }},
      '{8'h20, 8'hFF, 8'hFF, 1'b1, '{8'd171, 8'd85,  8'd0  }},
      '{8'h40, 8'hFF, 8'hFF, 1'b1, '{8'd171, 8'd170, 8'd0  }},
      '{8'h60, 8'hFF, 8'hFF, 1'b1, '{8'd0,   8'd255, 8'd0  }},
      '{8'h80, 8'hFF, 8'hFF, 1'b1, '{8'd0,   8'd171, 8'd85 }},
      '{8'hA0, 8'hFF, 8'hFF, 1'b1, '{8'd0,   8'd0,   8'd255}},
      '{8'hC0, 8'hFF, 8'hFF, 1'b1, '{8'd85,  8'd0,   8'd171}},
      '{8'hE0, 8'hFF, 8'hFF, 1'b1, '{8'd170, 8'd0,   8'd85 }},
      '{8'h37, 8'h00, 8'hFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{8'h9C, 8'h80, 8'h00, 1'b1, '{8'd0,   8'd0,   8'd0  }},
      '{8'hFF, 8'h00, 8'h00, 1'b1, '{8'd0,   8'd0,   8'd0  }},
      '{8'h1F, 8'hFF, 8'hFF, 1'b0, '0},
      '{8'h5F, 8'hFF, 8'hFF, 1'b0, '0},
      '{8'h9F, 8'hFF, 8'hFF, 1'b0, '0},
      '{8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
      '{8'h10, 8'h01, 8'hFF, 1'b0, '0},
      '{8'h70, 8'hFE, 8'hFF, 1'b0, '0},
      '{8'hD5, 8'hFF, 8'h01, 1'b0, '0},
      '{8'hB3, 8'h00, 8'hFE, 1'b0, '0},
      '{8'h4A, 8'h7F, 8'h80, 1'b0, '0}
   };

   // (a * (b + 1)) >> 8
   function automatic logic [7:0] frac_mul(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] prod;
      prod = {8'd0, a} * ({8'd0, b} + 16'd1);
      return prod[15:8];
   endfunction

   function automatic hrgb_color_type predict_rainbow_rgb(input logic [7:0] hue,
                                                          input logic [7:0] sat,
                                                          input logic [7:0] bri);
      logic [7:0]     pos;
      logic [7:0]     third;
      logic [7:0]     two3;
      logic [7:0]     white_floor;
      logic [7:0]     bri_sq;
      logic [8:0]     sum;
      logic [7:0]     ch [0:2];
      hrgb_color_type rgb;
      pos   = {hue[4:0] & POS_MASK, 3'b000};
      third = frac_mul(pos, LEVEL_THIRD);
      two3  = frac_mul(pos, LEVEL_TWO3);
      case (hrgb_seg_type'(hue[7:5]))
         SEG_RED: begin
            ch[0] = LEVEL_FULL - third; ch[1] = third; ch[2] = LEVEL_ZERO;
         end
         SEG_ORANGE: begin
            ch[0] = LEVEL_171; ch[1] = LEVEL_THIRD + third; ch[2] = LEVEL_ZERO;
         end
         SEG_YELLOW: begin
            ch[0] = LEVEL_171 - two3; ch[1] = LEVEL_TWO3 + third; ch[2] = LEVEL_ZERO;
         end
         SEG_GREEN: begin
            ch[0] = LEVEL_ZERO; ch[1] = LEVEL_FULL - third; ch[2] = third;
         end
         SEG_AQUA: begin
            ch[0] = LEVEL_ZERO; ch[1] = LEVEL_171 - two3; ch[2] = LEVEL_THIRD + two3;
         end
         SEG_BLUE: begin
            ch[0] = third; ch[1] = LEVEL_ZERO; ch[2] = LEVEL_FULL - third;
         end
         SEG_PURPLE: begin
            ch[0] = LEVEL_THIRD + third; ch[1] = LEVEL_ZERO; ch[2] = LEVEL_171 - third;
         end
         default: begin
            ch[0] = LEVEL_TWO3 + third; ch[1] = LEVEL_ZERO; ch[2] = LEVEL_THIRD - third;
         end
      endcase
      if (sat == LEVEL_ZERO) begin
         for (int i = 0; i < 3; i++) ch[i] = LEVEL_FULL;
      end else if (sat != LEVEL_FULL) begin
         white_floor = frac_mul(LEVEL_FULL - sat, LEVEL_FULL - sat);
         for (int i = 0; i < 3; i++) begin
            sum   = {1'b0, frac_mul(ch[i], sat)} + {1'b0, white_floor};
            ch[i] = sum[8] ? LEVEL_FULL : sum[7:0];
         end
      end
      if (bri != LEVEL_FULL) begin
         bri_sq = frac_mul(bri, bri);
         for (int i = 0; i < 3; i++) ch[i] = frac_mul(ch[i], bri_sq);
      end
      rgb.red   = ch[0];
      rgb.green = ch[1];
      rgb.blue  = ch[2];
      return rgb;
   endfunction

   // call at a rising edge; returns at the edge where the item is taken
   task automatic push_hsv(input logic [7:0] hue, input logic [7:0] sat,
                           input logic [7:0] bri, input hrgb_color_type rgb);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.hue_angle    <= hue;
      req_ch.sat_level    <= sat;
      req_ch.bright_level <= bri;
      next_rgb            <= rgb;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_level();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return LEVEL_ZERO;
      if (sel == 1) return LEVEL_FULL;
      return 8'($urandom);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[hsv_rainbow_to_rgb_unit] ERROR");
         $finish;
      end
   end

   // acceptance tracking and response check
   always @(posedge clock) begin
      hrgb_color_type want;
      if (!reset && req_ch.valid && req_ch.ready) rgb_expect_q.push_back(next_rgb);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rgb_expect_q.size() == 0) begin
            $error("unexpected rgb item %h/%h/%h",
                   rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out);
            err_count++;
         end else begin
            want = rgb_expect_q.pop_front();
            if (rsp_ch.red_out !== want.red) begin
               $error("red_out expected %0d got %0d", want.red, rsp_ch.red_out);
               err_count++;
            end
            if (rsp_ch.green_out !== want.green) begin
               $error("green_out expected %0d got %0d", want.green, rsp_ch.green_out);
               err_count++;
            end
            if (rsp_ch.blue_out !== want.blue) begin
               $error("blue_out expected %0d got %0d", want.blue, rsp_ch.blue_out);
               err_count++;
            end
         end
      end
   end

   initial begin
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] bri;
      send_idle_pct       = 27;
      recv_stall_pct      <= 69;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.hue_angle    <= '0;
      req_ch.sat_level    <= '0;
      req_ch.bright_level <= '0;
      next_rgb            <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         push_hsv(hsv_rows[i].hue, hsv_rows[i].sat, hsv_rows[i].bri,
                  hsv_rows[i].typed ? hsv_rows[i].rgb
                                    : predict_rainbow_rgb(hsv_rows[i].hue,
                                                          hsv_rows[i].sat,
                                                          hsv_rows[i].bri));
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) begin
            send_idle_pct  = 69;
            recv_stall_pct <= 27;
         end else if (i == 2 * N_RANDOM / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct <= 0;
         end
         hue = 8'($urandom);
         sat = pick_level();
         bri = pick_level();
         push_hsv(hue, sat, bri, predict_rainbow_rgb(hue, sat, bri));
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (rgb_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("[hsv_rainbow_to_rgb_unit] OK");
      end else begin
         $display("[hsv_rainbow_to_rgb_unit] ERROR");
      end
      $finish;
   end

endmodule
